### design/plcble_pkg.sv
package plcble_pkg;

  localparam int IMAGE_BYTES_DEF = 256;
  localparam int NEST_DEPTH_DEF  = 8;

  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] AREA_IN   = 2'd0;
  localparam logic [1:0] AREA_OUT  = 2'd1;
  localparam logic [1:0] AREA_MK   = 2'd2;
  localparam logic [1:0] AREA_NONE = 2'd3;

  localparam logic [2:0] TYPE_BIT = 3'd0;

  localparam logic [5:0] OP_LD    = 6'd0;
  localparam logic [5:0] OP_LDN   = 6'd1;
  localparam logic [5:0] OP_ST    = 6'd2;
  localparam logic [5:0] OP_STN   = 6'd3;
  localparam logic [5:0] OP_S     = 6'd4;
  localparam logic [5:0] OP_R     = 6'd5;
  localparam logic [5:0] OP_MOV   = 6'd6;
  localparam logic [5:0] OP_AND   = 6'd8;
  localparam logic [5:0] OP_ANDP  = 6'd9;
  localparam logic [5:0] OP_ANDN  = 6'd10;
  localparam logic [5:0] OP_ANDNP = 6'd11;
  localparam logic [5:0] OP_OR    = 6'd12;
  localparam logic [5:0] OP_ORP   = 6'd13;
  localparam logic [5:0] OP_ORN   = 6'd14;
  localparam logic [5:0] OP_ORNP  = 6'd15;
  localparam logic [5:0] OP_XOR   = 6'd16;
  localparam logic [5:0] OP_XORP  = 6'd17;
  localparam logic [5:0] OP_XORN  = 6'd18;
  localparam logic [5:0] OP_XORNP = 6'd19;
  localparam logic [5:0] OP_NOT   = 6'd20;
  localparam logic [5:0] OP_CLOSE = 6'd22;

  localparam logic [1:0] KIND_AND = 2'd0;
  localparam logic [1:0] KIND_OR  = 2'd1;
  localparam logic [1:0] KIND_XOR = 2'd2;

  localparam logic [7:0] BIT_ONE = 8'h01;

  typedef struct packed {
    logic [1:0] kind;
    logic       neg;
    logic       saved;
  } nest_entry_t;

  function automatic logic combine(input logic [1:0] kind, input logic a, input logic b);
    logic r;
    unique case (kind)
      KIND_AND: r = a & b;
      KIND_OR:  r = a | b;
      default:  r = a ^ b;
    endcase
    return r;
  endfunction

endpackage

### design/plc_bit_logic_executor_top.sv
// Results are registered into m_tdata as each item leaves the stage-1 registers.
// Throughput: one item per cycle unless m_tready stalls the output; the image
// memories are read at acceptance and written back as the item leaves stage 1, with the last
// write forwarded to the next item. Reset: synchronous; afterwards a clearing pass
// zeroes the three image memories, one address per cycle, while no input is accepted.
module plc_bit_logic_executor_top #(
  parameter int IMAGE_BYTES = plcble_pkg::IMAGE_BYTES_DEF,
  parameter int NEST_DEPTH  = plcble_pkg::NEST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode, operand_count, src_mem_type, src_area, src_bit, src_addr,
  // dst_mem_type, dst_area, dst_bit, dst_addr, write_data
  input  logic [47:0] s_tdata,
  // req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // accumulator_out, read_data, stack_fault, zero fill
  output logic [15:0] m_tdata
);

  localparam int AW = (IMAGE_BYTES > 1) ? $clog2(IMAGE_BYTES) : 1;
  localparam int XW = (AW > 8) ? AW : 8;
  localparam int SW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int PW = $clog2(NEST_DEPTH + 1);

  logic [7:0] input_mem  [IMAGE_BYTES];
  logic [7:0] output_mem [IMAGE_BYTES];
  logic [7:0] marker_mem [IMAGE_BYTES];

  logic          clr_busy;
  logic [AW-1:0] clr_cnt;

  logic          in_accept;
  logic          s1_fire;
  logic [XW-1:0] in_src_x;
  logic [XW-1:0] in_dst_x;
  logic [AW-1:0] in_src_idx;
  logic [AW-1:0] in_dst_idx;

  logic [7:0] in_rd_a;
  logic [7:0] out_rd_a;
  logic [7:0] out_rd_b;
  logic [7:0] mk_rd_a;
  logic [7:0] mk_rd_b;

  logic       s1_valid;
  logic [1:0] s1_req;
  logic [5:0] s1_op;
  logic [1:0] s1_cnt;
  logic [2:0] s1_st;
  logic [1:0] s1_sa;
  logic [2:0] s1_sb;
  logic [7:0] s1_sad;
  logic [2:0] s1_dt;
  logic [1:0] s1_da;
  logic [2:0] s1_db;
  logic [7:0] s1_dad;
  logic [7:0] s1_wd;

  logic       acc;
  logic       acc_next;
  logic [PW-1:0] nest_ptr;
  plcble_pkg::nest_entry_t nest_stack [NEST_DEPTH];
  plcble_pkg::nest_entry_t push_entry;
  plcble_pkg::nest_entry_t pop_entry;
  logic [PW-1:0] ptr_dec;
  logic [SW-1:0] pop_idx;

  logic       lw_valid;
  logic [1:0] lw_area;
  logic [7:0] lw_addr;
  logic [7:0] lw_data;

  logic [7:0] src_byte;
  logic [7:0] dst_byte;
  logic [7:0] src_val;
  logic       src_inr;
  logic       dst_inr;
  logic       src_ok;
  logic       src_wok;
  logic       dst_wok;
  logic       v;
  logic [1:0] op_kind;

  logic       we;
  logic [1:0] w_area;
  logic [7:0] w_addr;
  logic [7:0] w_data;
  logic       bit_wr;
  logic       bit_dst;
  logic       bit_val;
  logic [7:0] bit_base;
  logic [7:0] bit_mask;
  logic       push;
  logic       pop;
  logic       fault;
  logic [7:0] rd;

  logic [XW-1:0] w_x;
  logic [AW-1:0] w_idx;
  logic          mem_in_we;
  logic          mem_out_we;
  logic          mem_mk_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign s1_fire   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !clr_busy && (!s1_valid || s1_fire);
  assign in_accept = s_tvalid && s_tready;

  assign in_src_x   = XW'(s_tdata[23:16]);
  assign in_dst_x   = XW'(s_tdata[39:32]);
  assign in_src_idx = in_src_x[AW-1:0];
  assign in_dst_idx = in_dst_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == AW'(IMAGE_BYTES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_rd_a  <= input_mem[in_src_idx];
      out_rd_a <= output_mem[in_src_idx];
      out_rd_b <= output_mem[in_dst_idx];
      mk_rd_a  <= marker_mem[in_src_idx];
      mk_rd_b  <= marker_mem[in_dst_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_in_we) begin
      input_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_out_we) begin
      output_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_mk_we) begin
      marker_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req <= s_tuser;
      s1_op  <= s_tdata[5:0];
      s1_cnt <= s_tdata[7:6];
      s1_st  <= s_tdata[10:8];
      s1_sa  <= s_tdata[12:11];
      s1_sb  <= s_tdata[15:13];
      s1_sad <= s_tdata[23:16];
      s1_dt  <= s_tdata[26:24];
      s1_da  <= s_tdata[28:27];
      s1_db  <= s_tdata[31:29];
      s1_dad <= s_tdata[39:32];
      s1_wd  <= s_tdata[47:40];
    end
  end

  // The memory data may miss the write made at the edge this item was read.
  always_comb begin
    unique case (s1_sa)
      plcble_pkg::AREA_IN:
        src_byte = (lw_valid && lw_area == plcble_pkg::AREA_IN && lw_addr == s1_sad) ?
                   lw_data : in_rd_a;
      plcble_pkg::AREA_OUT:
        src_byte = (lw_valid && lw_area == plcble_pkg::AREA_OUT && lw_addr == s1_sad) ?
                   lw_data : out_rd_a;
      plcble_pkg::AREA_MK:
        src_byte = (lw_valid && lw_area == plcble_pkg::AREA_MK && lw_addr == s1_sad) ?
                   lw_data : mk_rd_a;
      default: src_byte = 8'h00;
    endcase
    unique case (s1_da)
      plcble_pkg::AREA_OUT:
        dst_byte = (lw_valid && lw_area == plcble_pkg::AREA_OUT && lw_addr == s1_dad) ?
                   lw_data : out_rd_b;
      plcble_pkg::AREA_MK:
        dst_byte = (lw_valid && lw_area == plcble_pkg::AREA_MK && lw_addr == s1_dad) ?
                   lw_data : mk_rd_b;
      default: dst_byte = 8'h00;
    endcase
  end

  assign src_inr = 32'(s1_sad) < 32'(IMAGE_BYTES);
  assign dst_inr = 32'(s1_dad) < 32'(IMAGE_BYTES);
  assign src_val = src_inr ? src_byte : 8'h00;
  assign src_ok  = (s1_st == plcble_pkg::TYPE_BIT) && (s1_sa != plcble_pkg::AREA_NONE);
  assign v       = src_val[s1_sb];
  assign src_wok = (s1_st == plcble_pkg::TYPE_BIT) && src_inr &&
                   (s1_sa == plcble_pkg::AREA_OUT || s1_sa == plcble_pkg::AREA_MK);
  assign dst_wok = (s1_dt == plcble_pkg::TYPE_BIT) && dst_inr &&
                   (s1_da == plcble_pkg::AREA_OUT || s1_da == plcble_pkg::AREA_MK);

  assign op_kind = s1_op[4] ? plcble_pkg::KIND_XOR :
                   (s1_op[2] ? plcble_pkg::KIND_OR : plcble_pkg::KIND_AND);

  assign ptr_dec   = nest_ptr - PW'(1);
  assign pop_idx   = ptr_dec[SW-1:0];
  assign pop_entry = nest_stack[pop_idx];

  always_comb begin
    acc_next   = acc;
    fault      = 1'b0;
    rd         = 8'h00;
    push       = 1'b0;
    pop        = 1'b0;
    bit_wr     = 1'b0;
    bit_dst    = 1'b0;
    bit_val    = 1'b0;
    we         = 1'b0;
    w_area     = s1_sa;
    w_addr     = s1_sad;
    push_entry = '{kind: op_kind, neg: s1_op[1], saved: acc};
    unique case (s1_req)
      plcble_pkg::REQ_WRITE: begin
        we     = src_inr;
        w_area = plcble_pkg::AREA_IN;
      end
      plcble_pkg::REQ_READ: begin
        rd = src_val;
      end
      plcble_pkg::REQ_EXEC: begin
        unique case (s1_op)
          plcble_pkg::OP_LD, plcble_pkg::OP_LDN: begin
            if (src_ok) begin
              acc_next = v ^ s1_op[0];
            end
          end
          plcble_pkg::OP_ST, plcble_pkg::OP_STN: begin
            bit_wr  = src_wok;
            bit_val = acc ^ s1_op[0];
          end
          plcble_pkg::OP_S, plcble_pkg::OP_R: begin
            bit_wr  = src_wok && acc;
            bit_val = (s1_op == plcble_pkg::OP_S);
          end
          plcble_pkg::OP_MOV: begin
            bit_wr  = dst_wok && acc;
            bit_dst = 1'b1;
            bit_val = src_ok && v;
            w_area  = s1_da;
            w_addr  = s1_dad;
          end
          plcble_pkg::OP_AND, plcble_pkg::OP_ANDN, plcble_pkg::OP_OR,
          plcble_pkg::OP_ORN, plcble_pkg::OP_XOR, plcble_pkg::OP_XORN: begin
            if (src_ok) begin
              acc_next = plcble_pkg::combine(op_kind, acc, v ^ s1_op[1]);
            end
          end
          plcble_pkg::OP_ANDP, plcble_pkg::OP_ANDNP, plcble_pkg::OP_ORP,
          plcble_pkg::OP_ORNP, plcble_pkg::OP_XORP, plcble_pkg::OP_XORNP: begin
            if (nest_ptr == PW'(NEST_DEPTH)) begin
              fault = 1'b1;
            end else begin
              push = 1'b1;
              if (s1_cnt == 2'd1 && src_ok) begin
                acc_next = v;
              end
            end
          end
          plcble_pkg::OP_NOT: begin
            acc_next = ~acc;
          end
          plcble_pkg::OP_CLOSE: begin
            if (nest_ptr == '0) begin
              fault = 1'b1;
            end else begin
              pop      = 1'b1;
              acc_next = plcble_pkg::combine(pop_entry.kind, acc, pop_entry.saved) ^
                         pop_entry.neg;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (bit_wr) begin
      we = 1'b1;
    end
  end

  assign bit_base = bit_dst ? dst_byte : src_byte;
  assign bit_mask = plcble_pkg::BIT_ONE << (bit_dst ? s1_db : s1_sb);
  assign w_data   = (s1_req == plcble_pkg::REQ_WRITE) ? s1_wd :
                    (bit_val ? (bit_base | bit_mask) : (bit_base & ~bit_mask));

  assign w_x   = XW'(w_addr);
  assign w_idx = w_x[AW-1:0];

  always_comb begin
    if (clr_busy) begin
      mem_in_we  = 1'b1;
      mem_out_we = 1'b1;
      mem_mk_we  = 1'b1;
      mem_waddr  = clr_cnt;
      mem_wdata  = 8'h00;
    end else begin
      mem_in_we  = s1_fire && we && (w_area == plcble_pkg::AREA_IN);
      mem_out_we = s1_fire && we && (w_area == plcble_pkg::AREA_OUT);
      mem_mk_we  = s1_fire && we && (w_area == plcble_pkg::AREA_MK);
      mem_waddr  = w_idx;
      mem_wdata  = w_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && push) begin
      nest_stack[nest_ptr[SW-1:0]] <= push_entry;
    end
    if (s1_fire && we) begin
      lw_area <= w_area;
      lw_addr <= w_addr;
      lw_data <= w_data;
    end
    if (s1_fire) begin
      m_tdata <= {6'b0, fault, rd, acc_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      acc      <= 1'b0;
      nest_ptr <= '0;
      lw_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        m_tvalid <= 1'b1;
        acc      <= acc_next;
        if (push) begin
          nest_ptr <= nest_ptr + PW'(1);
        end else if (pop) begin
          nest_ptr <= ptr_dec;
        end
        if (we) begin
          lw_valid <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    nest_ptr <= PW'(NEST_DEPTH))
    else $error("nesting pointer beyond stack depth");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready)
    else $error("input accepted during image clearing");

  a_fault_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && fault) |=> ($stable(nest_ptr) && $stable(acc)))
    else $error("stack fault changed pointer or accumulator");

  a_single_wr: assert property (@(posedge clk) disable iff (rst)
    !clr_busy |-> $onehot0({mem_in_we, mem_out_we, mem_mk_we}))
    else $error("more than one image written by one transaction");
`endif

endmodule
